### rtl/lbp_pkg.sv
// Shared types and constants for the local-history branch predictor.
// Depends on nothing; imported by the core and the top level.
`default_nettype none

package lbp_pkg;

	// Operation codes of a query transaction
	localparam logic OP_PREDICT = 1'b0;
	localparam logic OP_UPDATE  = 1'b1;

	// Two-bit saturating counter bounds and prediction threshold
	localparam logic [1:0] CTR_MIN     = 2'd0;
	localparam logic [1:0] CTR_MAX     = 2'd3;
	localparam logic [1:0] CTR_WEAK_NT = 2'd1;

	// Width of the reported history field
	localparam int unsigned HIST_OUT_W = 4;

	typedef struct packed {
		logic        op;
		logic [31:0] branch_address;
		logic        actual_taken;
	} query_t;

	typedef struct packed {
		logic                  predict_taken;
		logic [1:0]            counter_value;
		logic [HIST_OUT_W-1:0] history_value;
	} result_t;

endpackage

`default_nettype wire

### rtl/lbp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the history and counter tables.
`default_nettype none

module lbp_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, returns old data on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/lbp_core.sv
// Sequencer of the predictor: clearing pass, history read, counter read,
// counter and history write-back, and the result register.
// Depends on lbp_pkg; drives the two lbp_ram instances in the top level.
`default_nettype none

module lbp_core
	import lbp_pkg::*;
#(
	parameter int unsigned ADDR_INDEX_BITS = 4,
	parameter int unsigned HISTORY_BITS    = 4
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    query_valid,
	output logic                                         query_stall,
	input  wire query_t                                  query,
	output logic                                         result_valid,
	input  wire logic                                    result_stall,
	output result_t                                      result,
	// History table port
	output logic                                         hist_we,
	output logic [ADDR_INDEX_BITS-1:0]                   hist_waddr,
	output logic [HISTORY_BITS-1:0]                      hist_wdata,
	output logic [ADDR_INDEX_BITS-1:0]                   hist_raddr,
	input  wire logic [HISTORY_BITS-1:0]                 hist_rdata,
	// Counter table port
	output logic                                         ctr_we,
	output logic [ADDR_INDEX_BITS+HISTORY_BITS-1:0]      ctr_waddr,
	output logic [1:0]                                   ctr_wdata,
	output logic [ADDR_INDEX_BITS+HISTORY_BITS-1:0]      ctr_raddr,
	input  wire logic [1:0]                              ctr_rdata
);

	localparam int unsigned CTR_AW = ADDR_INDEX_BITS + HISTORY_BITS;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_HIST  = 5'b00100,
		ST_CTR   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t                     state_q;
	logic [CTR_AW-1:0]          clr_idx_q;
	logic [ADDR_INDEX_BITS-1:0] row_q;
	logic                       update_q;
	logic                       taken_q;
	logic                       result_valid_q;
	result_t                    result_q;

	logic       accept;
	logic       fire;
	logic [1:0] ctr_next;

	// Finish a transaction when the result register is free or being emptied
	assign fire        = (state_q == ST_DONE) && (!result_valid_q || !result_stall);
	assign query_stall = !((state_q == ST_IDLE) || fire);
	assign accept      = query_valid && !query_stall;

	// Saturate the selected counter towards the outcome
	always_comb begin
		ctr_next = ctr_rdata;
		if (taken_q) begin
			if (ctr_rdata != CTR_MAX) begin
				ctr_next = ctr_rdata + 2'd1;
			end
		end else begin
			if (ctr_rdata != CTR_MIN) begin
				ctr_next = ctr_rdata - 2'd1;
			end
		end
	end

	// Table reads follow the captured row and the history just read
	assign hist_raddr = row_q;
	assign ctr_raddr  = {row_q, hist_rdata};

	// Write back on update, or zero every entry during the clearing pass
	always_comb begin
		if (state_q == ST_CLEAR) begin
			hist_we    = 1'b1;
			hist_waddr = clr_idx_q[ADDR_INDEX_BITS-1:0];
			hist_wdata = '0;
			ctr_we     = 1'b1;
			ctr_waddr  = clr_idx_q;
			ctr_wdata  = CTR_MIN;
		end else begin
			hist_we    = fire && (update_q == OP_UPDATE);
			hist_waddr = row_q;
			hist_wdata = HISTORY_BITS'({hist_rdata, taken_q});
			ctr_we     = fire && (update_q == OP_UPDATE);
			ctr_waddr  = {row_q, hist_rdata};
			ctr_wdata  = ctr_next;
		end
	end

	// Sequencer and clearing index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_HIST;
					end
				end
				ST_HIST: state_q <= ST_CTR;
				ST_CTR:  state_q <= ST_DONE;
				ST_DONE: begin
					if (accept) begin
						state_q <= ST_HIST;
					end else if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// Capture the accepted transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q    <= query.branch_address[ADDR_INDEX_BITS-1:0];
			update_q <= query.op;
			taken_q  <= query.actual_taken;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Result payload: state as it stood before this transaction
	always_ff @(posedge clk) begin
		if (fire) begin
			result_q.predict_taken <= (ctr_rdata > CTR_WEAK_NT);
			result_q.counter_value <= ctr_rdata;
			result_q.history_value <= HIST_OUT_W'(hist_rdata);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

### rtl/local_two_bit_branch_predictor_top.sv
// Top level of the two-level local-history branch predictor.
// Depends on lbp_pkg, lbp_ram and lbp_core.
//
// Usage:
//   Query channel (query_valid, query_stall, query) carries one branch per
//   transaction: op selects predict or update, branch_address picks the
//   history row, actual_taken is the outcome on update.
//   Result channel (result_valid, result_stall, result) returns exactly one
//   transaction per query: the prediction, the selected counter and the
//   selected history as they stood before the query.
//   A query passes the history read, counter read and write-back states
//   before its result is registered; a new query is taken only as the last
//   one finishes, as the counter read depends on the history read, each
//   through a memory with registered read data. After reset both tables
//   are zeroed by a clearing pass over all 2^(ADDR_INDEX_BITS+HISTORY_BITS)
//   counter entries (256 at the defaults), during which query_stall is high.
//   While result_stall is high the result is held in the output register;
//   one further query may be accepted and worked on meanwhile, and it
//   completes once the output register frees.
`default_nettype none

module local_two_bit_branch_predictor_top
	import lbp_pkg::*;
#(
	parameter int unsigned ADDR_INDEX_BITS = 4,
	parameter int unsigned HISTORY_BITS    = 4
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    query_valid,
	output logic         query_stall,
	input  wire query_t  query,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	localparam int unsigned ROWS      = 1 << ADDR_INDEX_BITS;
	localparam int unsigned CTR_AW    = ADDR_INDEX_BITS + HISTORY_BITS;
	localparam int unsigned CTR_DEPTH = 1 << CTR_AW;

	logic                       hist_we;
	logic [ADDR_INDEX_BITS-1:0] hist_waddr;
	logic [HISTORY_BITS-1:0]    hist_wdata;
	logic [ADDR_INDEX_BITS-1:0] hist_raddr;
	logic [HISTORY_BITS-1:0]    hist_rdata;
	logic                       ctr_we;
	logic [CTR_AW-1:0]          ctr_waddr;
	logic [1:0]                 ctr_wdata;
	logic [CTR_AW-1:0]          ctr_raddr;
	logic [1:0]                 ctr_rdata;

	// Local history table
	lbp_ram #(
		.WIDTH(HISTORY_BITS),
		.DEPTH(ROWS)
	) u_hist_ram (
		.clk  (clk),
		.we   (hist_we),
		.waddr(hist_waddr),
		.wdata(hist_wdata),
		.raddr(hist_raddr),
		.rdata(hist_rdata)
	);

	// Two-bit counter table
	lbp_ram #(
		.WIDTH(2),
		.DEPTH(CTR_DEPTH)
	) u_ctr_ram (
		.clk  (clk),
		.we   (ctr_we),
		.waddr(ctr_waddr),
		.wdata(ctr_wdata),
		.raddr(ctr_raddr),
		.rdata(ctr_rdata)
	);

	// Sequencer and result register
	lbp_core #(
		.ADDR_INDEX_BITS(ADDR_INDEX_BITS),
		.HISTORY_BITS   (HISTORY_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.query_valid (query_valid),
		.query_stall (query_stall),
		.query       (query),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.hist_we     (hist_we),
		.hist_waddr  (hist_waddr),
		.hist_wdata  (hist_wdata),
		.hist_raddr  (hist_raddr),
		.hist_rdata  (hist_rdata),
		.ctr_we      (ctr_we),
		.ctr_waddr   (ctr_waddr),
		.ctr_wdata   (ctr_wdata),
		.ctr_raddr   (ctr_raddr),
		.ctr_rdata   (ctr_rdata)
	);

endmodule

`default_nettype wire
